@@ hw/rtl/bce_pkg.sv @@
// Package with the shared constants and the sequencer state type of the block entropy unit.
package bce_pkg;

    localparam int MAX_PIXELS = 64;
    localparam int FRAC_BITS  = 12;
    localparam int LOG_FRAC   = 24;
    localparam int MANT_BITS  = 30;

    localparam int COLOR_W  = 24;
    localparam int CNT_W    = $clog2(MAX_PIXELS + 1);
    localparam int IDX_W    = $clog2(MAX_PIXELS);
    localparam int EXP_W    = $clog2(CNT_W);
    localparam int LOG_W    = LOG_FRAC + EXP_W;
    localparam int MANT_W   = MANT_BITS + 1;
    localparam int STEP_W   = $clog2(LOG_FRAC + 1);
    localparam int PROD_W   = CNT_W + LOG_W;
    localparam int DEN_W    = CNT_W + LOG_FRAC - FRAC_BITS;
    localparam int DVD_W    = PROD_W + 1;
    localparam int DCNT_W   = $clog2(DVD_W + 1);
    localparam int ENT_W    = 15;
    localparam int OUT_W    = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_LOGN_GO,
        ST_LOGN_WAIT,
        ST_ENT_RD,
        ST_ENT_GO,
        ST_ENT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIN
    } state_t;

endpackage

@@ hw/rtl/bce_log2.sv @@
// Iterative fixed-point log2 unit built on one shared squaring multiplier.
module bce_log2
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bce_pkg::CNT_W-1:0]  k,
    output logic                       done,
    output logic [bce_pkg::LOG_W-1:0]  result
);

    logic [bce_pkg::MANT_W-1:0]     m_reg, m_next;
    logic [bce_pkg::LOG_FRAC-1:0]   frac_reg, frac_next;
    logic [bce_pkg::EXP_W-1:0]      exp_reg, exp_next;
    logic [bce_pkg::STEP_W-1:0]     step_reg, step_next;
    logic                           run_reg, run_next;
    logic                           done_reg, done_next;

    logic [2*bce_pkg::MANT_W-1:0]   sq;
    logic [bce_pkg::MANT_W:0]       sq_sh;
    logic [bce_pkg::EXP_W-1:0]      top_bit;
    logic [bce_pkg::CNT_W+bce_pkg::MANT_BITS-1:0] norm;

    // Index of the highest set bit of the argument.
    always_comb
    begin
        top_bit = '0;
        for (int i = 0; i < bce_pkg::CNT_W; i++)
        begin
            if (k[i])
            begin
                top_bit = bce_pkg::EXP_W'(i);
            end
        end
    end

    // Normalized mantissa and one squaring step.
    assign norm  = {k, {bce_pkg::MANT_BITS{1'b0}}} >> top_bit;
    assign sq    = m_reg * m_reg;
    assign sq_sh = sq[bce_pkg::MANT_BITS +: bce_pkg::MANT_W + 1];

    // Sequencing of the squaring steps; each one yields one fraction bit.
    always_comb
    begin
        m_next    = m_reg;
        frac_next = frac_reg;
        exp_next  = exp_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            m_next    = norm[bce_pkg::MANT_W-1:0];
            frac_next = '0;
            exp_next  = top_bit;
            step_next = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (sq_sh[bce_pkg::MANT_W])
            begin
                m_next = sq_sh[bce_pkg::MANT_W:1];
            end
            else
            begin
                m_next = sq_sh[bce_pkg::MANT_W-1:0];
            end
            frac_next = {frac_reg[bce_pkg::LOG_FRAC-2:0], sq_sh[bce_pkg::MANT_W]};
            step_next = step_reg + 1'b1;
            if (step_reg == bce_pkg::STEP_W'(bce_pkg::LOG_FRAC - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        frac_reg <= frac_next;
        exp_reg  <= exp_next;
        step_reg <= step_next;
    end

    assign done   = done_reg;
    assign result = {exp_reg, frac_reg};

endmodule

@@ hw/rtl/bce_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
module bce_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bce_pkg::DVD_W-1:0]  dividend,
    input  logic [bce_pkg::DEN_W-1:0]  divisor,
    output logic                       done,
    output logic [bce_pkg::DVD_W-1:0]  quotient
);

    logic [bce_pkg::DVD_W-1:0]   quo_reg, quo_next;
    logic [bce_pkg::DEN_W-1:0]   rem_reg, rem_next;
    logic [bce_pkg::DEN_W-1:0]   dsr_reg, dsr_next;
    logic [bce_pkg::DCNT_W-1:0]  cnt_reg, cnt_next;
    logic                        run_reg, run_next;
    logic                        done_reg, done_next;
    logic [bce_pkg::DEN_W:0]     trial;
    logic [bce_pkg::DEN_W:0]     diff;

    assign trial = {rem_reg, quo_reg[bce_pkg::DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    // One trial subtraction per cycle.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[bce_pkg::DEN_W-1:0];
                quo_next = {quo_reg[bce_pkg::DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[bce_pkg::DEN_W-1:0];
                quo_next = {quo_reg[bce_pkg::DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == bce_pkg::DCNT_W'(bce_pkg::DVD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hw/rtl/block_color_entropy_top.sv @@
// Top level: color table, search and entropy sequencer, and the stream ports.
// Sequence: a pixel is taken in the idle state; each table entry searched then adds a read state
// and a compare state (up to MAX_PIXELS-1 entries). A last pixel adds a log2 run per distinct
// color and one for the block size in the 24-step log2 unit, then a division and a result load.
// Throughput: one pixel at a time; the input is not ready while a pixel is worked on.
// Reset (asynchronous, active low) empties the block and drops any pending result.
module block_color_entropy_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [23:0] color
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // [14:0] entropy, [21:15] distinct_colors,
                                    // [28:22] pixel_count, [29] overflowed, [31:30] zero
);

    bce_pkg::state_t state_reg, state_next;

    logic [bce_pkg::COLOR_W-1:0] color_reg, color_next;
    logic                        last_reg, last_next;
    logic [bce_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [bce_pkg::CNT_W-1:0]   distinct_reg, distinct_next;
    logic [bce_pkg::CNT_W-1:0]   total_reg, total_next;
    logic                        ovf_reg, ovf_next;
    logic [bce_pkg::PROD_W-1:0]  pos_reg, pos_next;
    logic [bce_pkg::PROD_W-1:0]  acc_reg, acc_next;
    logic [bce_pkg::ENT_W-1:0]   ent_reg, ent_next;
    logic                        mval_reg, mval_next;
    logic [bce_pkg::OUT_W-1:0]   mdata_reg, mdata_next;

    // Color table memory.
    logic [bce_pkg::COLOR_W-1:0] key_mem [bce_pkg::MAX_PIXELS];
    logic [bce_pkg::CNT_W-1:0]   cnt_mem [bce_pkg::MAX_PIXELS];
    logic [bce_pkg::COLOR_W-1:0] rd_key_reg;
    logic [bce_pkg::CNT_W-1:0]   rd_cnt_reg;
    logic                        wr_en;
    logic [bce_pkg::IDX_W-1:0]   wr_addr;
    logic [bce_pkg::CNT_W-1:0]   wr_cnt;

    logic                        in_xfer;
    logic                        out_free;
    logic                        hit;
    logic                        last_entry;
    logic                        log_start;
    logic                        log_done;
    logic [bce_pkg::CNT_W-1:0]   log_k;
    logic [bce_pkg::LOG_W-1:0]   log_res;
    logic [bce_pkg::PROD_W-1:0]  prod;
    logic                        div_start;
    logic                        div_done;
    logic [bce_pkg::DVD_W-1:0]   div_dvd;
    logic [bce_pkg::DEN_W-1:0]   div_den;
    logic [bce_pkg::DVD_W-1:0]   div_quo;
    logic [bce_pkg::PROD_W-1:0]  diff;

    function automatic logic [bce_pkg::PROD_W-1:0] PROD_W_MUL
    (
        input logic [bce_pkg::CNT_W-1:0] a,
        input logic [bce_pkg::LOG_W-1:0] b
    );
        PROD_W_MUL = bce_pkg::PROD_W'(a) * bce_pkg::PROD_W'(b);
    endfunction

    assign in_xfer    = s_tvalid && s_tready;
    assign out_free   = !mval_reg || m_tready;
    assign hit        = (rd_key_reg == color_reg);
    assign last_entry = ({1'b0, idx_reg} + 1'b1) == distinct_reg;

    // Shared units.
    bce_log2 u_log2
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .k      (log_k),
        .done   (log_done),
        .result (log_res)
    );

    bce_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    // The block size feeds the log2 unit and the product while its log2 is taken.
    assign log_k   = (state_reg == bce_pkg::ST_LOGN_GO || state_reg == bce_pkg::ST_LOGN_WAIT)
                     ? total_reg : rd_cnt_reg;
    assign prod    = PROD_W_MUL(log_k, log_res);
    assign diff    = (pos_reg > acc_reg) ? (pos_reg - acc_reg) : '0;
    assign div_den = {total_reg, {(bce_pkg::LOG_FRAC - bce_pkg::FRAC_BITS){1'b0}}};
    assign div_dvd = {1'b0, diff} + bce_pkg::DVD_W'(div_den >> 1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bce_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (total_reg >= bce_pkg::CNT_W'(bce_pkg::MAX_PIXELS) ||
                        distinct_reg == '0)
                    begin
                        state_next = s_tlast ? bce_pkg::ST_LOGN_GO : bce_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = bce_pkg::ST_SRCH_RD;
                    end
                end
            end
            bce_pkg::ST_SRCH_RD:
            begin
                state_next = bce_pkg::ST_SRCH_CMP;
            end
            bce_pkg::ST_SRCH_CMP:
            begin
                if (hit || last_entry)
                begin
                    state_next = last_reg ? bce_pkg::ST_LOGN_GO : bce_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = bce_pkg::ST_SRCH_RD;
                end
            end
            bce_pkg::ST_LOGN_GO:
            begin
                state_next = (total_reg == '0) ? bce_pkg::ST_FIN : bce_pkg::ST_LOGN_WAIT;
            end
            bce_pkg::ST_LOGN_WAIT:
            begin
                if (log_done)
                begin
                    state_next = (distinct_reg == '0) ? bce_pkg::ST_DIV_GO
                                                      : bce_pkg::ST_ENT_RD;
                end
            end
            bce_pkg::ST_ENT_RD:
            begin
                state_next = bce_pkg::ST_ENT_GO;
            end
            bce_pkg::ST_ENT_GO:
            begin
                state_next = bce_pkg::ST_ENT_WAIT;
            end
            bce_pkg::ST_ENT_WAIT:
            begin
                if (log_done)
                begin
                    state_next = last_entry ? bce_pkg::ST_DIV_GO : bce_pkg::ST_ENT_RD;
                end
            end
            bce_pkg::ST_DIV_GO:
            begin
                state_next = bce_pkg::ST_DIV_WAIT;
            end
            bce_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = bce_pkg::ST_FIN;
                end
            end
            bce_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = bce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bce_pkg::ST_IDLE;
            end
        endcase
    end

    // Strobes to the table and the shared units.
    always_comb
    begin
        s_tready  = 1'b0;
        log_start = 1'b0;
        div_start = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = distinct_reg[bce_pkg::IDX_W-1:0];
        wr_cnt    = bce_pkg::CNT_W'(1);
        case (state_reg)
            bce_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (in_xfer && distinct_reg == '0 &&
                    total_reg < bce_pkg::CNT_W'(bce_pkg::MAX_PIXELS))
                begin
                    wr_en = 1'b1;
                end
            end
            bce_pkg::ST_SRCH_CMP:
            begin
                if (hit)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg;
                    wr_cnt  = rd_cnt_reg + 1'b1;
                end
                else if (last_entry)
                begin
                    wr_en = 1'b1;
                end
            end
            bce_pkg::ST_LOGN_GO:
            begin
                log_start = (total_reg != '0);
            end
            bce_pkg::ST_ENT_GO:
            begin
                log_start = 1'b1;
            end
            bce_pkg::ST_DIV_GO:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Block statistics, accumulators and the output register.
    always_comb
    begin
        color_next    = color_reg;
        last_next     = last_reg;
        idx_next      = idx_reg;
        distinct_next = distinct_reg;
        total_next    = total_reg;
        ovf_next      = ovf_reg;
        pos_next      = pos_reg;
        acc_next      = acc_reg;
        ent_next      = ent_reg;
        mval_next     = mval_reg && !m_tready;
        mdata_next    = mdata_reg;
        case (state_reg)
            bce_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    color_next = s_tdata;
                    last_next  = s_tlast;
                    idx_next   = '0;
                    ent_next   = '0;
                    if (total_reg >= bce_pkg::CNT_W'(bce_pkg::MAX_PIXELS))
                    begin
                        ovf_next = 1'b1;
                    end
                    else if (distinct_reg == '0)
                    begin
                        distinct_next = distinct_reg + 1'b1;
                        total_next    = total_reg + 1'b1;
                    end
                end
            end
            bce_pkg::ST_SRCH_CMP:
            begin
                if (hit)
                begin
                    total_next = total_reg + 1'b1;
                end
                else if (last_entry)
                begin
                    distinct_next = distinct_reg + 1'b1;
                    total_next    = total_reg + 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            bce_pkg::ST_LOGN_WAIT:
            begin
                if (log_done)
                begin
                    pos_next = prod;
                    acc_next = '0;
                    idx_next = '0;
                end
            end
            bce_pkg::ST_ENT_WAIT:
            begin
                if (log_done)
                begin
                    acc_next = acc_reg + prod;
                    if (!last_entry)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            bce_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (div_quo > bce_pkg::DVD_W'({bce_pkg::ENT_W{1'b1}}))
                    begin
                        ent_next = '1;
                    end
                    else
                    begin
                        ent_next = div_quo[bce_pkg::ENT_W-1:0];
                    end
                end
            end
            bce_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    mval_next     = 1'b1;
                    mdata_next    = {2'b00, ovf_reg, total_reg, distinct_reg, ent_reg};
                    distinct_next = '0;
                    total_next    = '0;
                    ovf_next      = 1'b0;
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bce_pkg::ST_IDLE;
            distinct_reg <= '0;
            total_reg    <= '0;
            ovf_reg      <= 1'b0;
            mval_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            distinct_reg <= distinct_next;
            total_reg    <= total_next;
            ovf_reg      <= ovf_next;
            mval_reg     <= mval_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        color_reg <= color_next;
        last_reg  <= last_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        acc_reg   <= acc_next;
        ent_reg   <= ent_next;
        mdata_reg <= mdata_next;
    end

    // Table write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= color_next;
            cnt_mem[wr_addr] <= wr_cnt;
        end
        rd_key_reg <= key_mem[idx_reg];
        rd_cnt_reg <= cnt_mem[idx_reg];
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;

endmodule
